// ----- rtl/sfrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_pkg
// Shared types, constants, microprogram and CRC step for the frame-to-packet
// unit.
// ----------------------------------------------------------------------------
package sfrp_pkg;

  localparam int FrameBytes = 28;
  localparam int SumBytes   = 25;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int CntW       = $clog2(FrameBytes + 1);
  localparam int StepW      = 6;

  // config register indexes
  localparam logic CfgFragment = 1'b0;
  localparam logic CfgKind     = 1'b1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [3:0] HdrCount  = 4'h4;
  localparam logic [7:0] TagHi     = 8'h01;
  localparam logic [7:0] RecLen    = 8'h04;
  localparam logic [7:0] TagLo0    = 8'h29;  // (0x4A << 2) | 1
  localparam logic [7:0] TagLo1    = 8'h2D;
  localparam logic [7:0] TagLo2    = 8'h31;
  localparam logic [7:0] TagLo3    = 8'h35;

  localparam logic [StepW-1:0] StepWait   = 6'd0;
  localparam logic [StepW-1:0] StepReject = 6'd38;

  typedef enum logic [2:0] {
    SRC_STORE,
    SRC_HDR,
    SRC_CONST,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_REJ
  } src_e;

  typedef enum logic [1:0] {
    JMP_WAIT,
    JMP_NEXT,
    JMP_HOME
  } jmp_e;

  typedef struct packed {
    src_e             src;
    logic [IdxW-1:0]  addr;
    logic [7:0]       konst;
    logic             emit;
    logic             last;
    logic             crc_en;
    logic             crc_init;
    jmp_e             jmp;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic pending;
    logic good;
    logic out_free;
  } dp_stat_t;

  function automatic ctrl_t uword(src_e src, logic [IdxW-1:0] addr, logic [7:0] konst,
                                  logic last, logic crc_en, jmp_e jmp);
    ctrl_t w;
    w.src      = src;
    w.addr     = addr;
    w.konst    = konst;
    w.emit     = 1'b1;
    w.last     = last;
    w.crc_en   = crc_en;
    w.crc_init = 1'b0;
    w.jmp      = jmp;
    w.target   = StepWait;
    return w;
  endfunction

  function automatic ctrl_t st(int a);
    return uword(SRC_STORE, IdxW'(a), 8'h00, 1'b0, 1'b1, JMP_NEXT);
  endfunction

  function automatic ctrl_t cb(logic [7:0] k);
    return uword(SRC_CONST, '0, k, 1'b0, 1'b1, JMP_NEXT);
  endfunction

  // microprogram: idle/branch, 35 body bytes, 2 check bytes, reject word
  function automatic ctrl_t ucode_rom(logic [StepW-1:0] step);
    ctrl_t w;
    w = uword(SRC_REJ, '0, 8'h00, 1'b1, 1'b0, JMP_HOME);
    case (step)
      6'd0: begin
        w.emit     = 1'b0;
        w.last     = 1'b0;
        w.crc_init = 1'b1;
        w.jmp      = JMP_WAIT;
        w.target   = StepReject;
      end
      6'd1:  w = st(19);
      6'd2:  w = st(20);
      6'd3:  w = st(21);
      6'd4:  w = st(22);
      6'd5:  w = st(23);
      6'd6:  w = st(24);
      6'd7:  w = uword(SRC_HDR, '0, 8'h00, 1'b0, 1'b1, JMP_NEXT);
      6'd8:  w = cb(TagLo0);
      6'd9:  w = cb(TagHi);
      6'd10: w = cb(RecLen);
      6'd11: w = st(3);
      6'd12: w = st(4);
      6'd13: w = st(5);
      6'd14: w = st(6);
      6'd15: w = cb(TagLo1);
      6'd16: w = cb(TagHi);
      6'd17: w = cb(RecLen);
      6'd18: w = st(7);
      6'd19: w = st(8);
      6'd20: w = st(9);
      6'd21: w = st(10);
      6'd22: w = cb(TagLo2);
      6'd23: w = cb(TagHi);
      6'd24: w = cb(RecLen);
      6'd25: w = st(11);
      6'd26: w = st(12);
      6'd27: w = st(13);
      6'd28: w = st(14);
      6'd29: w = cb(TagLo3);
      6'd30: w = cb(TagHi);
      6'd31: w = cb(RecLen);
      6'd32: w = st(15);
      6'd33: w = st(16);
      6'd34: w = st(17);
      6'd35: w = st(18);
      6'd36: w = uword(SRC_CRC_HI, '0, 8'h00, 1'b0, 1'b0, JMP_NEXT);
      6'd37: w = uword(SRC_CRC_LO, '0, 8'h00, 1'b1, 1'b0, JMP_HOME);
      default: w = uword(SRC_REJ, '0, 8'h00, 1'b1, 1'b0, JMP_HOME);
    endcase
    return w;
  endfunction

  // one byte of reflected CRC-16 (poly 0xA001)
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/sensor_frame_to_record_packet_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_to_record_packet_unit
// Collects a 28-byte sensor frame, checks it and sends a 37-byte record packet.
// ----------------------------------------------------------------------------
// Input channel: one frame word per accepted cycle (in_valid_i high, in_stall_o
// low), frame_end_i on the last word. One word is taken per unstalled cycle.
// Output channel: packet words with last_of_packet_o on the final one; a bad
// frame (wrong length or checksum) gives one word with status_o = 1, zero data.
// After the frame end word the input stalls until the last result word has
// been loaded into the output register. The frame end word sets the pending
// flag, the step counter then leaves the wait step and the first packet word
// is registered; the sequencer issues one word per cycle while the output is
// not stalled. A receiver stall holds the output register and freezes the
// step counter outside the wait step. Config writes (cfg_we_i, cfg_idx_i,
// cfg_data_i) are for the user to make only while idle; the block does not
// enforce this. Reset clears counters, config, step counter and the output
// valid; the frame store itself is not cleared.
// ----------------------------------------------------------------------------
module sensor_frame_to_record_packet_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] frame_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] packet_byte_o,
  output logic       last_of_packet_o,
  output logic       status_o
);

  logic               fragment_flag_q;
  logic [2:0]         packet_kind_q;
  sfrp_pkg::ctrl_t    ctrl;
  sfrp_pkg::dp_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fragment_flag_q <= 1'b0;
      packet_kind_q   <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfrp_pkg::CfgFragment: fragment_flag_q <= cfg_data_i[0];
        sfrp_pkg::CfgKind:     packet_kind_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfrp_useq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  sfrp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .frame_byte_i     (frame_byte_i),
    .frame_end_i      (frame_end_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .fragment_flag_i  (fragment_flag_q),
    .packet_kind_i    (packet_kind_q),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .packet_byte_o    (packet_byte_o),
    .last_of_packet_o (last_of_packet_o),
    .status_o         (status_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

endmodule

// ----- rtl/sfrp_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_useq
// Step counter and microprogram ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sfrp_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfrp_pkg::dp_stat_t stat_i,
  output sfrp_pkg::ctrl_t   ctrl_o
);

  logic [sfrp_pkg::StepW-1:0] pc_q, pc_d;
  sfrp_pkg::ctrl_t            ctrl;

  assign ctrl   = sfrp_pkg::ucode_rom(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    pc_d = pc_q;
    case (ctrl.jmp)
      sfrp_pkg::JMP_WAIT: begin
        // branch on frame check once a frame has ended
        if (stat_i.pending) begin
          pc_d = stat_i.good ? pc_q + sfrp_pkg::StepW'(1) : ctrl.target;
        end
      end
      sfrp_pkg::JMP_NEXT: begin
        if (stat_i.out_free) begin
          pc_d = pc_q + sfrp_pkg::StepW'(1);
        end
      end
      sfrp_pkg::JMP_HOME: begin
        if (stat_i.out_free) begin
          pc_d = sfrp_pkg::StepWait;
        end
      end
      default: pc_d = sfrp_pkg::StepWait;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= sfrp_pkg::StepWait;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- rtl/sfrp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrp_datapath
// Frame store, running checksum, CRC register, byte mux and output register.
// ----------------------------------------------------------------------------
module sfrp_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         frame_byte_i,
  input  logic               frame_end_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               fragment_flag_i,
  input  logic [2:0]         packet_kind_i,
  input  sfrp_pkg::ctrl_t    ctrl_i,
  output sfrp_pkg::dp_stat_t stat_o,
  output logic [7:0]         packet_byte_o,
  output logic               last_of_packet_o,
  output logic               status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  logic [7:0]                store_q [sfrp_pkg::FrameBytes];
  logic [sfrp_pkg::CntW-1:0] seen_q;
  logic                      ovf_q;
  logic [15:0]               sum_q;
  logic                      pending_q, good_q;
  logic [15:0]               crc_q;
  logic                      out_valid_q;
  logic [7:0]                byte_q;
  logic                      last_q, status_q;

  logic       in_acc, room, frame_ok, out_free, fire, done;
  logic [7:0] byte_d;

  assign in_stall_o = pending_q;
  assign in_acc     = in_valid_i && !pending_q;
  assign room       = seen_q < sfrp_pkg::CntW'(sfrp_pkg::FrameBytes);
  // last byte arriving as index 27 means exactly 28 bytes
  assign frame_ok   = !ovf_q
                   && (seen_q == sfrp_pkg::CntW'(sfrp_pkg::FrameBytes - 1))
                   && (sum_q == {store_q[26], store_q[25]});

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = ctrl_i.emit && out_free;
  assign done     = fire && (ctrl_i.jmp == sfrp_pkg::JMP_HOME);

  assign stat_o.pending  = pending_q;
  assign stat_o.good     = good_q;
  assign stat_o.out_free = out_free;

  always_comb begin
    case (ctrl_i.src)
      sfrp_pkg::SRC_STORE:  byte_d = store_q[ctrl_i.addr];
      sfrp_pkg::SRC_HDR:    byte_d = {sfrp_pkg::HdrCount, fragment_flag_i, packet_kind_i};
      sfrp_pkg::SRC_CONST:  byte_d = ctrl_i.konst;
      sfrp_pkg::SRC_CRC_HI: byte_d = crc_q[15:8];
      sfrp_pkg::SRC_CRC_LO: byte_d = crc_q[7:0];
      default:              byte_d = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      store_q[seen_q[sfrp_pkg::IdxW-1:0]] <= frame_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      ovf_q     <= 1'b0;
      sum_q     <= '0;
      pending_q <= 1'b0;
      good_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        if (frame_end_i) begin
          seen_q    <= '0;
          ovf_q     <= 1'b0;
          sum_q     <= '0;
          pending_q <= 1'b1;
          good_q    <= frame_ok;
        end else begin
          if (room) begin
            seen_q <= seen_q + sfrp_pkg::CntW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          if (seen_q < sfrp_pkg::CntW'(sfrp_pkg::SumBytes)) begin
            sum_q <= sum_q + {8'h00, frame_byte_i};
          end
        end
      end else if (done) begin
        pending_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= sfrp_pkg::CrcInit;
    end else if (ctrl_i.crc_init) begin
      crc_q <= sfrp_pkg::CrcInit;
    end else if (fire && ctrl_i.crc_en) begin
      crc_q <= sfrp_pkg::crc_byte(crc_q, byte_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q   <= byte_d;
      last_q   <= ctrl_i.last;
      status_q <= (ctrl_i.src == sfrp_pkg::SRC_REJ);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign packet_byte_o    = byte_q;
  assign last_of_packet_o = last_q;
  assign status_o         = status_q;

endmodule

// ----- tb/sv/tb_sensor_frame_to_record_packet_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_to_record_packet_unit
// Feeds sensor frames into the unit with random input gaps and output stalls.
// The frames are good, carry a bad checksum, are short or are long. For each
// frame the bench predicts the record packet or the reject word, and it
// checks every output word in order against that prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       rej;
} pkt_word_t;

typedef logic [7:0] byte_q_t[$];

class packet_tracker;
  logic [7:0]  store [sfrp_pkg::FrameBytes];
  int unsigned fill    = 0;
  bit          overrun = 1'b0;
  logic        frag    = 1'b0;
  logic [2:0]  kind    = 3'd0;
  pkt_word_t   due_words[$];
  int unsigned errors  = 0;

  function void set_reg(logic idx, logic [2:0] val);
    if (idx == sfrp_pkg::CfgFragment) begin
      frag = val[0];
    end else begin
      kind = val;
    end
  endfunction

  // store one frame word; at frame end queue the packet or the reject word
  function void take_frame_word(logic [7:0] b, logic e);
    logic [7:0]  pkt [37];
    logic [15:0] sum;
    logic [15:0] crc;
    logic [15:0] tag;
    bit          good;
    int          pos;
    if (fill < sfrp_pkg::FrameBytes) begin
      store[fill] = b;
      fill++;
    end else begin
      overrun = 1'b1;
    end
    if (!e) return;
    good = !overrun && (fill == sfrp_pkg::FrameBytes);
    if (good) begin
      sum = 16'h0000;
      for (int i = 0; i < 25; i++) sum = sum + {8'h00, store[i]};
      good = (sum == {store[26], store[25]});
    end
    fill    = 0;
    overrun = 1'b0;
    if (!good) begin
      due_words.push_back('{data: 8'h00, last: 1'b1, rej: 1'b1});
      return;
    end
    for (int i = 0; i < 6; i++) pkt[i] = store[19 + i];
    pkt[6] = {4'h4, frag, kind};
    pos = 7;
    for (int r = 0; r < 4; r++) begin
      tag = 16'((((32'h4A + r) << 2) | 32'h1));
      pkt[pos]     = tag[7:0];
      pkt[pos + 1] = tag[15:8];
      pkt[pos + 2] = 8'h04;
      for (int i = 0; i < 4; i++) pkt[pos + 3 + i] = store[3 + 4 * r + i];
      pos += 7;
    end
    // CRC-16, reflected, over the 35 body bytes
    crc = 16'hFFFF;
    for (int i = 0; i < 35; i++) begin
      crc = crc ^ {8'h00, pkt[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    pkt[35] = crc[15:8];
    pkt[36] = crc[7:0];
    for (int i = 0; i < 37; i++) begin
      due_words.push_back('{data: pkt[i], last: (i == 36), rej: 1'b0});
    end
  endfunction

  function void check_packet_word(logic [7:0] d, logic l, logic s);
    pkt_word_t want;
    if (due_words.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected word: data %h last %b status %b", d, l, s);
      return;
    end
    want = due_words.pop_front();
    if (want.data !== d || want.last !== l || want.rej !== s) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: want data %h last %b status %b, got data %h last %b status %b",
                 want.data, want.last, want.rej, d, l, s);
      end
    end
  endfunction
endclass

module tb_sensor_frame_to_record_packet_unit;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_idx_i    = 1'b0;
  logic [2:0] cfg_data_i   = 3'd0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] frame_byte_i = 8'h00;
  logic       frame_end_i  = 1'b0;
  logic       out_stall_i  = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] packet_byte_o;
  logic       last_of_packet_o;
  logic       status_o;

  packet_tracker trk;
  bit            calm     = 1'b0;  // no gaps or stalls once set
  int unsigned   gap_odds = 0;     // 0: no input gaps for this frame
  int unsigned   words_sent = 0;

  sensor_frame_to_record_packet_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .frame_byte_i     (frame_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .packet_byte_o    (packet_byte_o),
    .last_of_packet_o (last_of_packet_o),
    .status_o         (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: check accepted words, stall in random bursts
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        trk.check_packet_word(packet_byte_o, last_of_packet_o, status_o);
      end
      if (hold == 0 && !calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 10);
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic e);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_end_i  <= e;
    do @(posedge clk_i); while (in_stall_o);
    trk.take_frame_word(b, e);
    words_sent++;
  endtask

  task automatic send_frame(input byte_q_t fr);
    gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
    foreach (fr[i]) send_word(fr[i], i == fr.size() - 1);
  endtask

  // drain, then write both registers back to back
  task automatic set_header(input logic fr, input logic [2:0] kd);
    logic [2:0] frag_word;
    frag_word = {2'($urandom_range(0, 3)), fr};
    in_valid_i <= 1'b0;
    while (trk.due_words.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sfrp_pkg::CfgFragment;
    cfg_data_i <= frag_word;
    @(posedge clk_i);
    trk.set_reg(sfrp_pkg::CfgFragment, frag_word);
    cfg_idx_i  <= sfrp_pkg::CfgKind;
    cfg_data_i <= kd;
    @(posedge clk_i);
    trk.set_reg(sfrp_pkg::CfgKind, kd);
    cfg_we_i <= 1'b0;
  endtask

  function automatic byte_q_t with_sum(input byte_q_t fr);
    logic [15:0] sum;
    sum = 16'h0000;
    for (int i = 0; i < 25; i++) sum = sum + {8'h00, fr[i]};
    fr[25] = sum[7:0];
    fr[26] = sum[15:8];
    return fr;
  endfunction

  function automatic byte_q_t random_frame(input int unsigned len);
    byte_q_t fr;
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
    return fr;
  endfunction

  initial begin
    byte_q_t     fr;
    int unsigned goal;
    int unsigned until_cfg;
    int unsigned pick;
    trk = new;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero frame under reset header settings
    fr = {};
    repeat (28) fr.push_back(8'h00);
    send_frame(with_sum(fr));
    set_header(1'b1, 3'd7);
    fr = {};
    repeat (28) fr.push_back(8'hFF);
    send_frame(with_sum(fr));
    // one-word frame, then a frame one word short
    send_frame(random_frame(1));
    fr = with_sum(random_frame(28));
    void'(fr.pop_back());
    send_frame(fr);
    // good content with one extra word
    fr = with_sum(random_frame(28));
    fr.push_back(8'($urandom));
    send_frame(fr);
    // checksum low byte, then high byte, off
    fr = with_sum(random_frame(28));
    fr[25] = fr[25] ^ 8'($urandom_range(1, 255));
    send_frame(fr);
    fr = with_sum(random_frame(28));
    fr[26] = fr[26] ^ 8'($urandom_range(1, 255));
    send_frame(fr);
    set_header(1'b0, 3'd0);
    send_frame(with_sum(random_frame(28)));

    goal      = words_sent + 200;
    until_cfg = $urandom_range(2, 5);
    while (words_sent < goal) begin
      if (words_sent + 100 > goal) calm = 1'b1;
      if (until_cfg == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          set_header(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 3'd7 : 3'd0);
        end else begin
          set_header(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
        until_cfg = $urandom_range(2, 5);
      end
      until_cfg--;
      pick = $urandom_range(0, 9);
      fr   = with_sum(random_frame(28));
      if (pick == 7) begin
        fr[$urandom_range(0, 26)] ^= 8'($urandom_range(1, 255));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 27)) void'(fr.pop_back());
      end else if (pick == 9) begin
        repeat ($urandom_range(1, 12)) fr.push_back(8'($urandom));
      end
      send_frame(fr);
    end

    in_valid_i <= 1'b0;
    while (trk.due_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (trk.errors == 0 && trk.due_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sfrp_pkg.sv
rtl/sfrp_useq.sv
rtl/sfrp_datapath.sv
rtl/sensor_frame_to_record_packet_unit.sv
tb/sv/tb_sensor_frame_to_record_packet_unit.sv
